/* hw/rtl/mupe_pkg.sv */
// ----------------------------------------------------------------------------
// mupe_pkg - shared types and constants for the max-unpool plane engine
// Opcodes, the command word passed front to back, the result word and the
// back-end sequencer states.
// ----------------------------------------------------------------------------
package mupe_pkg;

   localparam int OPC_W  = 2;
   localparam int IDX_W  = 16;
   localparam int VAL_W  = 32;
   localparam int SIZE_W = 13;

   // plane size after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

   // saturation limits of Q16.16
   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

   typedef enum logic [OPC_W-1:0] {
      OP_WRITE      = 2'd0,
      OP_READ_CLEAR = 2'd1,
      OP_GATHER     = 2'd2
   } opcode_type;

   // classified command: raw opcode (code 3 is a no-op) plus range check
   typedef struct packed {
      logic [OPC_W-1:0]        opcode;
      logic                    hit;
      logic [IDX_W-1:0]        index;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    in_range;
      logic                    saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'd0,
      BK_IDLE  = 2'd1,
      BK_READ  = 2'd2
   } back_state_type;

endpackage

/* hw/rtl/mupe_ram.sv */
// ----------------------------------------------------------------------------
// mupe_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mupe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/mupe_fifo.sv */
// ----------------------------------------------------------------------------
// mupe_fifo - small register queue
// Used between front and back and in front of the result port.
// ----------------------------------------------------------------------------
module mupe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wptr_ff, wptr_in;
   logic [PtrW-1:0]  rptr_ff, rptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign full    = (cnt_ff == FullCnt);
   assign empty   = (cnt_ff == '0);
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == LastPtr) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == LastPtr) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/mupe_front.sv */
// ----------------------------------------------------------------------------
// mupe_front - request intake and classification
// Holds the plane size register, checks the index against the live size
// and pushes a classified command word into the command queue.
// ----------------------------------------------------------------------------
module mupe_front #(
   parameter int PLANE_DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [mupe_pkg::SIZE_W-1:0]          csr_wr_data,
   input  logic                                 req_push,
   input  logic [mupe_pkg::OPC_W-1:0]           req_opcode,
   input  logic [mupe_pkg::IDX_W-1:0]           req_index,
   input  logic signed [mupe_pkg::VAL_W-1:0]    req_value,
   output logic                                 req_full,
   input  logic                                 cmd_full,
   input  logic                                 clearing,
   output logic                                 cmd_push,
   output mupe_pkg::cmd_type                    cmd_data
);
   import mupe_pkg::*;

   // 17 bits hold both a 16-bit index and a depth of 65536
   localparam int LiveW = IDX_W + 1;
   localparam logic [LiveW-1:0] DepthW = LiveW'(PLANE_DEPTH);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [LiveW-1:0]  size_ext;
   logic [LiveW-1:0]  live_size;

   assign size_in   = csr_wr_en ? csr_wr_data : size_ff;
   assign size_ext  = LiveW'(size_ff);
   assign live_size = (size_ext < DepthW) ? size_ext : DepthW;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // no intake while the store is being zeroed
   assign req_full = cmd_full || clearing;
   assign cmd_push = req_push && !req_full;

   always_comb begin
      cmd_data.opcode = req_opcode;
      cmd_data.hit    = ({1'b0, req_index} < live_size);
      cmd_data.index  = req_index;
      cmd_data.value  = req_value;
   end

endmodule

/* hw/rtl/mupe_back.sv */
// ----------------------------------------------------------------------------
// mupe_back - plane store sequencer
// Zeroes the store after reset, then executes one command at a time
// against the plane RAM and pushes one result word per command.
// ----------------------------------------------------------------------------
module mupe_back #(
   parameter int PLANE_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_empty,
   input  mupe_pkg::cmd_type   cmd_data,
   output logic                cmd_pop,
   input  logic                rsp_full,
   output logic                rsp_push,
   output mupe_pkg::rsp_type   rsp_data,
   output logic                clearing
);
   import mupe_pkg::*;

   localparam int AddrW = $clog2(PLANE_DEPTH);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(PLANE_DEPTH - 1);

   back_state_type state_ff, state_in;
   logic [AddrW-1:0] clr_ff, clr_in;
   cmd_type          cur_ff, cur_in;

   logic             ram_we;
   logic [AddrW-1:0] ram_waddr;
   logic [VAL_W-1:0] ram_wdata;
   logic             ram_re;
   logic [AddrW-1:0] ram_raddr;
   logic [VAL_W-1:0] ram_rdata;

   logic signed [VAL_W:0]   sum;
   logic                    sum_ovf;
   logic signed [VAL_W-1:0] sum_sat;

   mupe_ram #(
      .WIDTH(VAL_W),
      .DEPTH(PLANE_DEPTH)
   ) u_plane (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // gather: 33-bit exact sum, clipped to Q16.16
   assign sum     = {cur_ff.value[VAL_W-1], cur_ff.value}
                  + {ram_rdata[VAL_W-1], ram_rdata};
   assign sum_ovf = sum[VAL_W] ^ sum[VAL_W-1];
   assign sum_sat = !sum_ovf ? sum[VAL_W-1:0] : (sum[VAL_W] ? VAL_MIN : VAL_MAX);

   assign clearing = (state_ff == BK_CLEAR);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_data  = '0;
      ram_we    = 1'b0;
      ram_waddr = cur_ff.index[AddrW-1:0];
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = cmd_data.index[AddrW-1:0];
      unique case (state_ff)
         BK_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LastAddr) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            // one result slot is always free for the command in flight
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_data;
               case (cmd_data.opcode) inside
                  OP_WRITE: begin
                     ram_we            = cmd_data.hit;
                     ram_waddr         = cmd_data.index[AddrW-1:0];
                     ram_wdata         = cmd_data.value;
                     rsp_push          = 1'b1;
                     rsp_data.in_range = cmd_data.hit;
                  end
                  OP_READ_CLEAR, OP_GATHER: begin
                     if (cmd_data.hit) begin
                        ram_re   = 1'b1;
                        state_in = BK_READ;
                     end else begin
                        rsp_push = 1'b1;
                        if (cmd_data.opcode == OP_GATHER) begin
                           rsp_data.value = cmd_data.value;
                        end
                     end
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            rsp_push          = 1'b1;
            rsp_data.in_range = 1'b1;
            state_in          = BK_IDLE;
            if (cur_ff.opcode == OP_GATHER) begin
               rsp_data.value     = sum_sat;
               rsp_data.saturated = sum_ovf;
            end else begin
               ram_we         = 1'b1;
               rsp_data.value = ram_rdata;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

/* hw/rtl/max_unpool_plane_engine.sv */
// ----------------------------------------------------------------------------
// max_unpool_plane_engine - max-unpooling plane store with scatter/read/gather
// One channel plane of signed Q16.16 entries. Write scatters a value to a
// mask index, read-and-clear drains and zeroes an entry, gather adds the
// stored entry to a gradient value with saturation.
// ----------------------------------------------------------------------------
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  -------------------
//  request   req_opcode, req_index, req_value             req_push / req_full
//  result    rsp_result_value, rsp_in_range, rsp_saturated rsp_pop / rsp_empty
//  config    csr_wr_data (plane size)                     csr_wr_en
//
//  After reset the plane store is zeroed, one entry per cycle, with
//  req_full held high meanwhile. Config writes are taken throughout.
//  Write, out-of-range and no-op words finish in the back end as they are
//  taken; read-and-clear and in-range gather need a registered RAM read,
//  then sum or zero write-back, before the back end takes the next word.
//  A 2-deep command queue lets intake run ahead of the back end; a 2-deep
//  result queue holds results while rsp_pop is low.
//  Accepted words pass the command queue, back end and result queue in turn.
// ----------------------------------------------------------------------------
module max_unpool_plane_engine #(
   parameter int PLANE_DEPTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [mupe_pkg::SIZE_W-1:0]        csr_wr_data,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [mupe_pkg::OPC_W-1:0]         req_opcode,
   input  logic [mupe_pkg::IDX_W-1:0]         req_index,
   input  logic signed [mupe_pkg::VAL_W-1:0]  req_value,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [mupe_pkg::VAL_W-1:0]  rsp_result_value,
   output logic                               rsp_in_range,
   output logic                               rsp_saturated
);
   import mupe_pkg::*;

   localparam int QDepth = 2;

   // front -> command queue
   logic    cmd_push, cmd_full;
   cmd_type cmd_in_word;
   // command queue -> back
   logic    cmd_pop, cmd_empty;
   cmd_type cmd_out_word;
   // back -> result queue
   logic    res_push, res_full;
   rsp_type res_in_word;
   rsp_type res_out_word;
   logic    clearing;

   mupe_front #(
      .PLANE_DEPTH(PLANE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_push   (req_push),
      .req_opcode (req_opcode),
      .req_index  (req_index),
      .req_value  (req_value),
      .req_full   (req_full),
      .cmd_full   (cmd_full),
      .clearing   (clearing),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in_word)
   );

   mupe_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(QDepth)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_in_word),
      .pop      (cmd_pop),
      .pop_data (cmd_out_word),
      .full     (cmd_full),
      .empty    (cmd_empty)
   );

   mupe_back #(
      .PLANE_DEPTH(PLANE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_data (cmd_out_word),
      .cmd_pop  (cmd_pop),
      .rsp_full (res_full),
      .rsp_push (res_push),
      .rsp_data (res_in_word),
      .clearing (clearing)
   );

   mupe_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(QDepth)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_in_word),
      .pop      (rsp_pop),
      .pop_data (res_out_word),
      .full     (res_full),
      .empty    (rsp_empty)
   );

   assign rsp_result_value = res_out_word.value;
   assign rsp_in_range     = res_out_word.in_range;
   assign rsp_saturated    = res_out_word.saturated;

`ifndef SYNTHESIS
   // back end never pushes a result into a full result queue
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result queue overflow");

   // back end never pops an empty command queue
   a_no_cmd_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command queue underflow");

   // saturation is only reported for an operation that was performed
   a_sat_in_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturated) |-> rsp_in_range)
      else $error("saturated result without in_range");

   // no request is accepted while the store is being zeroed
   a_no_cmd_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!cmd_push && cmd_empty))
      else $error("command queued during clearing pass");
`endif

endmodule
